// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AST_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/avralu_pkg.sv =====
package avralu_pkg;

    typedef logic [5:0] t_cmd;

    localparam t_cmd CMD_ADD    = 6'd0;
    localparam t_cmd CMD_ADC    = 6'd1;
    localparam t_cmd CMD_ADIW   = 6'd2;
    localparam t_cmd CMD_SUB    = 6'd3;
    localparam t_cmd CMD_SUBI   = 6'd4;
    localparam t_cmd CMD_SBC    = 6'd5;
    localparam t_cmd CMD_SBCI   = 6'd6;
    localparam t_cmd CMD_SBIW   = 6'd7;
    localparam t_cmd CMD_AND    = 6'd8;
    localparam t_cmd CMD_ANDI   = 6'd9;
    localparam t_cmd CMD_OR     = 6'd10;
    localparam t_cmd CMD_ORI    = 6'd11;
    localparam t_cmd CMD_EOR    = 6'd12;
    localparam t_cmd CMD_COM    = 6'd13;
    localparam t_cmd CMD_NEG    = 6'd14;
    localparam t_cmd CMD_INC    = 6'd15;
    localparam t_cmd CMD_DEC    = 6'd16;
    localparam t_cmd CMD_MUL    = 6'd17;
    localparam t_cmd CMD_MULS   = 6'd18;
    localparam t_cmd CMD_MULSU  = 6'd19;
    localparam t_cmd CMD_FMUL   = 6'd20;
    localparam t_cmd CMD_FMULS  = 6'd21;
    localparam t_cmd CMD_FMULSU = 6'd22;
    localparam t_cmd CMD_CP     = 6'd23;
    localparam t_cmd CMD_CPC    = 6'd24;
    localparam t_cmd CMD_CPI    = 6'd25;
    localparam t_cmd CMD_MOV    = 6'd26;
    localparam t_cmd CMD_MOVW   = 6'd27;
    localparam t_cmd CMD_LSL    = 6'd28;
    localparam t_cmd CMD_LSR    = 6'd29;
    localparam t_cmd CMD_ASR    = 6'd30;
    localparam t_cmd CMD_BST    = 6'd31;
    localparam t_cmd CMD_BLD    = 6'd32;

    // status register bit positions
    localparam int F_C = 0;
    localparam int F_Z = 1;
    localparam int F_N = 2;
    localparam int F_V = 3;
    localparam int F_S = 4;
    localparam int F_H = 5;
    localparam int F_T = 6;
    localparam int F_UNUSED = 7;

    localparam logic [7:0]  C_SIGN8  = 8'h80;
    localparam logic [7:0]  C_SMAX8  = 8'h7F;
    localparam logic [7:0]  C_ONE8   = 8'h01;
    localparam logic [15:0] C_HI_MSK = 16'hFF00;

    // Register file is split in an even bank and an odd bank, 16 rows each.
    localparam int RF_ROWS = 16;
    typedef logic [$clog2(RF_ROWS)-1:0] t_row;

    typedef struct packed {
        logic       we_e;
        logic       we_o;
        t_row       row;
        logic [7:0] data_e;
        logic [7:0] data_o;
    } t_rf_wr;

    typedef struct packed {
        logic [7:0] d_even;
        logic [7:0] d_odd;
        logic [7:0] r_even;
        logic [7:0] r_odd;
    } t_rf_rd;

endpackage

// ===== hdl/avralu_rf.sv =====
module avralu_rf
    import avralu_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_re,
    input  t_row   i_row_d,
    input  t_row   i_row_r,
    input  t_rf_wr i_wr,
    output t_rf_rd o_rd
);

    logic [7:0] r_mem_e [RF_ROWS];
    logic [7:0] r_mem_o [RF_ROWS];
    logic [RF_ROWS-1:0] r_vld_e;
    logic [RF_ROWS-1:0] r_vld_o;

    logic [7:0] r_q_de, r_q_do, r_q_re, r_q_ro;
    logic       r_v_de, r_v_do, r_v_re, r_v_ro;
    t_row       r_row_d, r_row_r;
    t_rf_wr     r_fw;

    always_ff @(posedge i_clk) begin
        if (i_wr.we_e) begin
            r_mem_e[i_wr.row] <= i_wr.data_e;
        end
        if (i_wr.we_o) begin
            r_mem_o[i_wr.row] <= i_wr.data_o;
        end
    end

    // registered read, two rows per bank
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q_de  <= r_mem_e[i_row_d];
            r_q_do  <= r_mem_o[i_row_d];
            r_q_re  <= r_mem_e[i_row_r];
            r_q_ro  <= r_mem_o[i_row_r];
            r_v_de  <= r_vld_e[i_row_d];
            r_v_do  <= r_vld_o[i_row_d];
            r_v_re  <= r_vld_e[i_row_r];
            r_v_ro  <= r_vld_o[i_row_r];
            r_row_d <= i_row_d;
            r_row_r <= i_row_r;
        end
    end

    // valid bits: never-written rows read as zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_e <= '0;
            r_vld_o <= '0;
        end else begin
            if (i_wr.we_e) begin
                r_vld_e[i_wr.row] <= 1'b1;
            end
            if (i_wr.we_o) begin
                r_vld_o[i_wr.row] <= 1'b1;
            end
        end
    end

    // last write, bypassed over the read taken at the same edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw.we_e <= 1'b0;
            r_fw.we_o <= 1'b0;
        end else if (i_wr.we_e || i_wr.we_o) begin
            r_fw <= i_wr;
        end
    end

    always_comb begin
        o_rd.d_even = (r_fw.we_e && r_fw.row == r_row_d) ? r_fw.data_e :
                      (r_v_de ? r_q_de : 8'h00);
        o_rd.d_odd  = (r_fw.we_o && r_fw.row == r_row_d) ? r_fw.data_o :
                      (r_v_do ? r_q_do : 8'h00);
        o_rd.r_even = (r_fw.we_e && r_fw.row == r_row_r) ? r_fw.data_e :
                      (r_v_re ? r_q_re : 8'h00);
        o_rd.r_odd  = (r_fw.we_o && r_fw.row == r_row_r) ? r_fw.data_o :
                      (r_v_ro ? r_q_ro : 8'h00);
    end

endmodule

// ===== hdl/avralu_exec.sv =====
module avralu_exec
    import avralu_pkg::*;
(
    input  t_cmd        i_cmd,
    input  logic [4:0]  i_dst,
    input  logic [4:0]  i_src,
    input  logic [7:0]  i_imm,
    input  logic [2:0]  i_bit,
    input  t_rf_rd      i_rd,
    input  logic [7:0]  i_sreg,
    output logic [15:0] o_result,
    output logic [7:0]  o_sreg,
    output t_rf_wr      o_wr
);

    typedef struct packed {
        logic [7:0] res;
        logic       h;
        logic       v;
        logic       c;
    } t_alu8;

    function automatic t_alu8 f_add8(input logic [7:0] d, input logic [7:0] r,
                                     input logic cin);
        t_alu8      o;
        logic [8:0] s;
        s = {1'b0, d} + {1'b0, r} + {8'h00, cin};
        o.res = s[7:0];
        o.h = (d[3] & r[3]) | (r[3] & ~o.res[3]) | (~o.res[3] & d[3]);
        o.v = (d[7] & r[7] & ~o.res[7]) | (~d[7] & ~r[7] & o.res[7]);
        o.c = (d[7] & r[7]) | (r[7] & ~o.res[7]) | (~o.res[7] & d[7]);
        return o;
    endfunction

    function automatic t_alu8 f_sub8(input logic [7:0] d, input logic [7:0] r,
                                     input logic cin);
        t_alu8      o;
        logic [8:0] s;
        s = {1'b0, d} - {1'b0, r} - {8'h00, cin};
        o.res = s[7:0];
        o.h = (~d[3] & r[3]) | (r[3] & o.res[3]) | (o.res[3] & ~d[3]);
        o.v = (d[7] & ~r[7] & ~o.res[7]) | (~d[7] & r[7] & o.res[7]);
        o.c = (~d[7] & r[7]) | (r[7] & o.res[7]) | (o.res[7] & ~d[7]);
        return o;
    endfunction

    logic [7:0]  rd, rr;
    logic [15:0] word, spair;
    logic        cin;
    logic        sgn_d, sgn_r, frac;
    logic signed [8:0]  mul_a, mul_b;
    logic signed [17:0] prod;
    logic [15:0] mul_raw, mul_res;

    assign rd    = i_dst[0] ? i_rd.d_odd : i_rd.d_even;
    assign rr    = i_src[0] ? i_rd.r_odd : i_rd.r_even;
    assign word  = {i_rd.d_odd, i_rd.d_even};
    assign spair = {i_rd.r_odd, i_rd.r_even};
    assign cin   = i_sreg[F_C];

    // one 9x9 signed multiplier covers all six multiply forms
    always_comb begin
        sgn_d = 1'b0;
        sgn_r = 1'b0;
        frac  = 1'b0;
        case (i_cmd)
            CMD_MULS:   begin sgn_d = 1'b1; sgn_r = 1'b1; end
            CMD_MULSU:  begin sgn_d = 1'b1; end
            CMD_FMUL:   begin frac = 1'b1; end
            CMD_FMULS:  begin sgn_d = 1'b1; sgn_r = 1'b1; frac = 1'b1; end
            CMD_FMULSU: begin sgn_d = 1'b1; frac = 1'b1; end
            default:    begin end
        endcase
    end

    assign mul_a   = $signed({sgn_d & rd[7], rd});
    assign mul_b   = $signed({sgn_r & rr[7], rr});
    assign prod    = mul_a * mul_b;
    assign mul_raw = prod[15:0];
    assign mul_res = frac ? {mul_raw[14:0], 1'b0} : mul_raw;

    always_comb begin
        t_alu8       a8;
        logic [7:0]  s;
        logic [7:0]  v8;
        logic [7:0]  nz_val;
        logic [15:0] res16;
        logic [16:0] w17;
        logic        wr8, nzs, sticky;
        a8      = '0;
        s       = i_sreg;
        v8      = 8'h00;
        nz_val  = 8'h00;
        res16   = 16'h0000;
        w17     = '0;
        wr8     = 1'b0;
        nzs     = 1'b0;
        sticky  = 1'b0;
        o_wr    = '0;
        o_wr.row = i_dst[4:1];
        case (i_cmd)
            CMD_ADD, CMD_ADC: begin
                a8 = f_add8(rd, rr, (i_cmd == CMD_ADC) & cin);
                s[F_H] = a8.h; s[F_V] = a8.v; s[F_C] = a8.c;
                v8 = a8.res; nz_val = a8.res; nzs = 1'b1; wr8 = 1'b1;
            end
            CMD_SUB, CMD_SUBI, CMD_SBC, CMD_SBCI, CMD_CP, CMD_CPC, CMD_CPI: begin
                case (i_cmd)
                    CMD_SUB:  a8 = f_sub8(rd, rr, 1'b0);
                    CMD_SUBI: a8 = f_sub8(rd, i_imm, 1'b0);
                    CMD_SBC:  a8 = f_sub8(rd, rr, cin);
                    CMD_SBCI: a8 = f_sub8(rd, i_imm, cin);
                    CMD_CP:   a8 = f_sub8(rd, rr, 1'b0);
                    CMD_CPC:  a8 = f_sub8(rd, rr, cin);
                    default:  a8 = f_sub8(rd, i_imm, 1'b0);
                endcase
                s[F_H] = a8.h; s[F_V] = a8.v; s[F_C] = a8.c;
                v8 = a8.res; nz_val = a8.res; nzs = 1'b1;
                sticky = (i_cmd == CMD_SBC) || (i_cmd == CMD_SBCI) || (i_cmd == CMD_CPC);
                wr8 = (i_cmd == CMD_SUB) || (i_cmd == CMD_SUBI) ||
                      (i_cmd == CMD_SBC) || (i_cmd == CMD_SBCI);
                res16 = {8'h00, a8.res};
            end
            CMD_ADIW, CMD_SBIW: begin
                if (i_cmd == CMD_ADIW) begin
                    w17 = {1'b0, word} + {11'b0, i_imm[5:0]};
                    s[F_V] = ~word[15] & w17[15];
                    s[F_C] = ~w17[15] & word[15];
                end else begin
                    w17 = {1'b0, word} - {11'b0, i_imm[5:0]};
                    s[F_V] = word[15] & ~w17[15];
                    s[F_C] = w17[15] & ~word[15];
                end
                s[F_N] = w17[15];
                s[F_Z] = (w17[15:0] == 16'h0000);
                s[F_S] = s[F_N] ^ s[F_V];
                res16 = w17[15:0];
                o_wr.we_e = 1'b1; o_wr.we_o = 1'b1;
                o_wr.data_e = w17[7:0];
                o_wr.data_o = w17[15:8];
            end
            CMD_AND, CMD_ANDI, CMD_OR, CMD_ORI, CMD_EOR, CMD_COM: begin
                case (i_cmd)
                    CMD_AND:  v8 = rd & rr;
                    CMD_ANDI: v8 = rd & i_imm;
                    CMD_OR:   v8 = rd | rr;
                    CMD_ORI:  v8 = rd | i_imm;
                    CMD_EOR:  v8 = rd ^ rr;
                    default:  v8 = ~rd;
                endcase
                s[F_V] = 1'b0;
                if (i_cmd == CMD_COM) begin
                    s[F_C] = 1'b1;
                end
                nz_val = v8; nzs = 1'b1; wr8 = 1'b1;
            end
            CMD_NEG: begin
                v8 = 8'h00 - rd;
                s[F_H] = v8[3] | rd[3];
                s[F_V] = (v8 == C_SIGN8);
                s[F_C] = (v8 != 8'h00);
                nz_val = v8; nzs = 1'b1; wr8 = 1'b1;
            end
            CMD_INC: begin
                v8 = rd + C_ONE8;
                s[F_V] = (v8 == C_SIGN8);
                nz_val = v8; nzs = 1'b1; wr8 = 1'b1;
            end
            CMD_DEC: begin
                v8 = rd - C_ONE8;
                s[F_V] = (v8 == C_SMAX8);
                nz_val = v8; nzs = 1'b1; wr8 = 1'b1;
            end
            CMD_MUL, CMD_MULS, CMD_MULSU, CMD_FMUL, CMD_FMULS, CMD_FMULSU: begin
                s[F_C] = mul_raw[15];
                s[F_Z] = (mul_res == 16'h0000);
                res16 = mul_res;
                o_wr.row = '0;
                o_wr.we_e = 1'b1; o_wr.we_o = 1'b1;
                o_wr.data_e = mul_res[7:0];
                o_wr.data_o = mul_res[15:8];
            end
            CMD_MOV: begin
                v8 = rr; wr8 = 1'b1;
            end
            CMD_MOVW: begin
                res16 = spair;
                o_wr.we_e = 1'b1; o_wr.we_o = 1'b1;
                o_wr.data_e = spair[7:0];
                o_wr.data_o = spair[15:8];
            end
            CMD_LSL, CMD_LSR, CMD_ASR: begin
                case (i_cmd)
                    CMD_LSL: begin
                        v8 = {rd[6:0], 1'b0};
                        s[F_H] = rd[3];
                        s[F_C] = rd[7];
                    end
                    CMD_LSR: begin
                        v8 = {1'b0, rd[7:1]};
                        s[F_C] = rd[0];
                    end
                    default: begin
                        v8 = {rd[7], rd[7:1]};
                        s[F_C] = rd[0];
                    end
                endcase
                s[F_N] = v8[7];
                s[F_Z] = (v8 == 8'h00);
                s[F_V] = s[F_N] ^ s[F_C];
                s[F_S] = s[F_N] ^ s[F_V];
                wr8 = 1'b1;
            end
            CMD_BST: begin
                s[F_T] = rd[i_bit];
                res16 = {8'h00, rd};
            end
            CMD_BLD: begin
                v8 = rd;
                v8[i_bit] = i_sreg[F_T];
                wr8 = 1'b1;
            end
            default: begin end
        endcase

        if (nzs) begin
            s[F_N] = nz_val[7];
            s[F_Z] = (nz_val == 8'h00);
            s[F_S] = s[F_N] ^ s[F_V];
        end
        // carry forms only clear Z, never set it
        if (sticky) begin
            s[F_Z] = (nz_val == 8'h00) & i_sreg[F_Z];
        end
        if (wr8) begin
            res16 = {8'h00, v8};
            o_wr.we_e = ~i_dst[0];
            o_wr.we_o = i_dst[0];
            o_wr.data_e = v8;
            o_wr.data_o = v8;
        end
        s[F_UNUSED] = 1'b0;
        o_sreg   = s;
        o_result = res16 & ((wr8 || (i_cmd == CMD_BST) || sticky ||
                            (i_cmd == CMD_CP) || (i_cmd == CMD_CPI) ||
                            (i_cmd == CMD_SUB) || (i_cmd == CMD_SUBI)) ?
                            ~C_HI_MSK : 16'hFFFF);
    end

endmodule

// ===== hdl/avr_alu_with_status_flags_unit.sv =====
// Channel   Direction  Handshake          Word
// --------  ---------  -----------------  -------------------------------------------
// input     in         i_valid / o_stall  i_cmd, i_dest_reg, i_src_reg, i_imm, i_bit_sel
// result    out        o_valid / i_stall  o_result_value, o_status_flags
//
// One word per cycle sustained while i_stall is low; o_valid rises once the word moves
// from the execute stage into the output register.
// The register file is read first (synchronous banked memory, registered read).
// Then the word executes, writes back to the memory and the status register, and loads the output.
// A write and the next word's read at the same edge are bypassed in the register file.
// Reset clears control, status register and the register file valid bits (no sweep).
// A stalled result holds the execute stage; o_stall rises only when both are full.
`include "assert_macros.svh"

module avr_alu_with_status_flags_unit
    import avralu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [5:0]  i_cmd,
    input  logic [4:0]  i_dest_reg,
    input  logic [4:0]  i_src_reg,
    input  logic [7:0]  i_imm,
    input  logic [2:0]  i_bit_sel,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_result_value,
    output logic [7:0]  o_status_flags
);

    // execute stage
    logic        r_evld;
    t_cmd        r_cmd;
    logic [4:0]  r_dst;
    logic [4:0]  r_src;
    logic [7:0]  r_imm;
    logic [2:0]  r_bit;

    // architectural status register
    logic [7:0]  r_sreg;
    logic [7:0]  n_sreg;

    // output register
    logic        r_ovld;
    logic [15:0] r_res;
    logic [7:0]  r_flags;

    logic        slot_ok;   // output register free or draining this cycle
    logic        e_adv;     // execute word moves to the output register
    logic        in_acc;
    logic [15:0] n_res;
    t_rf_wr      ex_wr;
    t_rf_wr      rf_wr;
    t_rf_rd      rf_rd;

    assign slot_ok = !r_ovld || !i_stall;
    assign e_adv   = r_evld && slot_ok;
    assign in_acc  = i_valid && (!r_evld || slot_ok);
    assign o_stall = r_evld && !slot_ok;

    avralu_rf u_rf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (in_acc),
        .i_row_d (i_dest_reg[4:1]),
        .i_row_r (i_src_reg[4:1]),
        .i_wr    (rf_wr),
        .o_rd    (rf_rd)
    );

    avralu_exec u_exec (
        .i_cmd    (r_cmd),
        .i_dst    (r_dst),
        .i_src    (r_src),
        .i_imm    (r_imm),
        .i_bit    (r_bit),
        .i_rd     (rf_rd),
        .i_sreg   (r_sreg),
        .o_result (n_res),
        .o_sreg   (n_sreg),
        .o_wr     (ex_wr)
    );

    // commit to the register file only when the word leaves execute
    always_comb begin
        rf_wr      = ex_wr;
        rf_wr.we_e = ex_wr.we_e && e_adv;
        rf_wr.we_o = ex_wr.we_o && e_adv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_evld <= 1'b0;
        end else if (!r_evld || slot_ok) begin
            r_evld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd <= i_cmd;
            r_dst <= i_dest_reg;
            r_src <= i_src_reg;
            r_imm <= i_imm;
            r_bit <= i_bit_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sreg <= 8'h00;
        end else if (e_adv) begin
            r_sreg <= n_sreg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (slot_ok) begin
            r_ovld <= r_evld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_adv) begin
            r_res   <= n_res;
            r_flags <= n_sreg;
        end
    end

    assign o_valid        = r_ovld;
    assign o_result_value = r_res;
    assign o_status_flags = r_flags;

    // a held execute word is never dropped while the input side is stalled
    `AST_NEXT(a_hold_exec, i_clk, i_rst_n, o_stall, r_evld)
    // a new result only appears behind an execute word
    `AST_SAME(a_out_from_exec, i_clk, i_rst_n, $rose(r_ovld), $past(r_evld))
    // the unused status bit stays clear
    `AST_SAME(a_sreg_bit7, i_clk, i_rst_n, r_ovld, !o_status_flags[F_UNUSED])

endmodule
